// File: design/bps_pkg.sv
// bps_pkg: shared types, codes and pattern table for the beep pattern sequencer
// no dependencies
`timescale 1ns / 1ps

package bps_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned PulseW = 4;
  localparam int unsigned TickW  = 10;

  // event codes carried on the op field
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_RING   = 3'b010,
    PH_SILENT = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [PulseW-1:0]  pulses_done;
    logic [PulseW-1:0]  pulse_limit;
    logic [TickW-1:0]   on_ticks;
    logic [TickW-1:0]   off_ticks;
    logic [TickW-1:0]   countdown;
    logic               drive_level;
  } seq_state_t;

  typedef struct packed {
    logic [PulseW-1:0] pulses;
    logic [TickW-1:0]  on_t;
    logic [TickW-1:0]  off_t;
    logic              valid;
  } pattern_t;

  // fixed pattern table: pulses, on ticks, off ticks
  function automatic pattern_t pattern_lookup(input logic [ModeW-1:0] mode);
    pattern_t p;
    p = '0;
    unique case (mode)
      3'd1:    p = '{pulses: 4'd8, on_t: 10'd150, off_t: 10'd150, valid: 1'b1};
      3'd2:    p = '{pulses: 4'd4, on_t: 10'd500, off_t: 10'd50,  valid: 1'b1};
      3'd3:    p = '{pulses: 4'd5, on_t: 10'd1,   off_t: 10'd1,   valid: 1'b1};
      3'd4:    p = '{pulses: 4'd8, on_t: 10'd15,  off_t: 10'd15,  valid: 1'b1};
      3'd5:    p = '{pulses: 4'd2, on_t: 10'd1,   off_t: 10'd1,   valid: 1'b1};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: design/bps_core.sv
// bps_core: next-state logic of the sequencer for one event
// depends on bps_pkg
`timescale 1ns / 1ps

module bps_core
  import bps_pkg::*;
(
  input  seq_state_t              cur,
  input  logic       [OpW-1:0]    op,
  input  logic       [ModeW-1:0]  mode,
  output seq_state_t              nxt
);

  pattern_t pat;
  op_t      op_e;

  assign pat  = pattern_lookup(mode);
  assign op_e = op_t'(op);

  always_comb begin
    nxt = cur;
    unique case (op_e)
      OP_TICK: begin
        if (cur.phase != PH_IDLE) begin
          if (cur.countdown != '0) begin
            nxt.countdown = cur.countdown - 1'b1;
          end else begin
            unique case (cur.phase)
              PH_RING: begin
                nxt.drive_level = 1'b0;
                nxt.phase       = PH_SILENT;
                nxt.countdown   = cur.off_ticks;
              end
              PH_SILENT: begin
                nxt.pulses_done = cur.pulses_done + 1'b1;
                if ((cur.pulses_done + 1'b1) >= cur.pulse_limit) begin
                  nxt.phase = PH_IDLE;
                end else begin
                  nxt.drive_level = 1'b1;
                  nxt.phase       = PH_RING;
                  nxt.countdown   = cur.on_ticks;
                end
              end
              default: nxt.phase = PH_IDLE;
            endcase
          end
        end
      end
      OP_START: begin
        if (cur.phase == PH_IDLE) begin
          nxt.pulses_done = '0;
          if (pat.valid) begin
            nxt.pulse_limit = pat.pulses;
            nxt.on_ticks    = pat.on_t;
            nxt.off_ticks   = pat.off_t;
            nxt.phase       = PH_RING;
            nxt.drive_level = 1'b1;
            nxt.countdown   = pat.on_t;
          end
        end
      end
      OP_STOP: begin
        nxt.phase       = PH_IDLE;
        nxt.drive_level = 1'b0;
      end
      default: nxt = cur;
    endcase
  end

endmodule

// File: design/beep_pattern_sequencer.sv
// beep_pattern_sequencer: top level, input register, state and result register
// depends on bps_pkg and bps_core
`timescale 1ns / 1ps
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+---------------------------
//  input    | in_valid, in_ready, in_op, in_mode      | one event transaction
//  result   | out_valid, out_ready, out_buzzer_on,    | one status transaction
//           | out_busy_res                            | per event
//
//  one event per cycle sustained while the result side does not stall; an event
//  passes the input register, then the state update and result register
//  synchronous active-low reset returns the sequencer state to idle with the drive level low
//  a stalled result holds the pipeline; the input register still takes a
//  transaction while the result register is full only if it is itself empty

module beep_pattern_sequencer
  import bps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OpW-1:0]    in_op,
  input  logic [ModeW-1:0]  in_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_buzzer_on,
  output logic              out_busy_res
);

  // input register
  logic              s1_vld_r;
  logic [OpW-1:0]    s1_op_r;
  logic [ModeW-1:0]  s1_mode_r;

  // result register
  logic              out_vld_r;
  logic              out_buzzer_r;
  logic              out_busy_r;

  // sequencer state
  seq_state_t        state_r;
  seq_state_t        state_nxt;

  logic              advance;
  logic              in_take;

  // the event in the input register moves on when the result slot is empty or being taken
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  bps_core u_core (
    .cur  (state_r),
    .op   (s1_op_r),
    .mode (s1_mode_r),
    .nxt  (state_nxt)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= s1_vld_r;
        if (s1_vld_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_mode_r <= in_mode;
    end
    if (advance && s1_vld_r) begin
      out_buzzer_r <= state_nxt.drive_level;
      out_busy_r   <= (state_nxt.phase != PH_IDLE);
    end
  end

  assign out_valid     = out_vld_r;
  assign out_buzzer_on = out_buzzer_r;
  assign out_busy_res  = out_busy_r;

`ifndef SYNTHESIS
  // buzzer is never driven while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_IDLE) |-> !state_r.drive_level)
    else $error("buzzer driven while idle");

  // a running pattern has pulses left
  a_pulses_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != PH_IDLE) |-> (state_r.pulses_done < state_r.pulse_limit))
    else $error("running with no pulses left");

  // countdown stays within the current phase time
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r.phase == PH_RING) |-> (state_r.countdown <= state_r.on_ticks)) and
    ((state_r.phase == PH_SILENT) |-> (state_r.countdown <= state_r.off_ticks)))
    else $error("countdown beyond phase time");

  // state moves only when an event leaves the input register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_vld_r) |=> $stable(state_r))
    else $error("state changed without an event");
`endif

endmodule

// File: tb/tb_beep_pattern_sequencer.sv
// tb_beep_pattern_sequencer: self-checking testbench for the beep pattern sequencer
// predicts buzzer and busy status per event; depends on bps_pkg and beep_pattern_sequencer
`timescale 1ns / 1ps

module tb_beep_pattern_sequencer;
  import bps_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_ITEMS  = 150;     // tail of the run with no idling
  localparam int HOLD_AT      = 400;     // transaction count that triggers the long stall
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;      // margin after the drain to watch for stray results
  localparam int CYCLE_LIMIT  = 200000;

  // one expected status transaction
  typedef struct packed {
    logic buzzer_on;
    logic busy;
  } status_t;

  // pattern predictor and queue of status transactions still owed by the block
  class beep_scoreboard;
    phase_t            phase       = PH_IDLE;
    logic [PulseW-1:0] pulses_done = '0;
    logic [PulseW-1:0] pulse_limit = '0;
    logic [TickW-1:0]  on_len      = '0;
    logic [TickW-1:0]  off_len     = '0;
    logic [TickW-1:0]  countdown   = '0;
    logic              drive       = 1'b0;
    status_t           expected_status[$];
    int                errors      = 0;

    function bit running();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // advance the pattern by one accepted event and queue the status it yields
    function void apply_event(op_t op, logic [ModeW-1:0] mode);
      status_t           s;
      logic              known;
      logic [PulseW-1:0] cnt;
      logic [TickW-1:0]  t_on;
      logic [TickW-1:0]  t_off;
      known = 1'b1;
      cnt   = '0;
      t_on  = '0;
      t_off = '0;
      case (op)
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (countdown != '0) begin
              countdown = countdown - 1'b1;
            end else if (phase == PH_RING) begin
              drive     = 1'b0;
              phase     = PH_SILENT;
              countdown = off_len;
            end else if (phase == PH_SILENT) begin
              pulses_done = pulses_done + 1'b1;
              if (pulses_done >= pulse_limit) begin
                phase = PH_IDLE;
              end else begin
                drive     = 1'b1;
                phase     = PH_RING;
                countdown = on_len;
              end
            end else begin
              phase = PH_IDLE;
            end
          end
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            pulses_done = '0;
            case (mode)
              3'd1: begin cnt = 4'd8; t_on = 10'd150; t_off = 10'd150; end
              3'd2: begin cnt = 4'd4; t_on = 10'd500; t_off = 10'd50;  end
              3'd3: begin cnt = 4'd5; t_on = 10'd1;   t_off = 10'd1;   end
              3'd4: begin cnt = 4'd8; t_on = 10'd15;  t_off = 10'd15;  end
              3'd5: begin cnt = 4'd2; t_on = 10'd1;   t_off = 10'd1;   end
              default: known = 1'b0;
            endcase
            if (known) begin
              pulse_limit = cnt;
              on_len      = t_on;
              off_len     = t_off;
              phase       = PH_RING;
              drive       = 1'b1;
              countdown   = t_on;
            end
          end
        end
        OP_STOP: begin
          phase = PH_IDLE;
          drive = 1'b0;
        end
        default: ;
      endcase
      s.buzzer_on = drive;
      s.busy      = (phase != PH_IDLE);
      expected_status.push_back(s);
    endfunction

    // compare one accepted status transaction with the oldest prediction
    function void check_status(logic buzzer_on, logic busy);
      status_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, buzzer_on %0b busy %0b", $time, buzzer_on, busy);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      if (want.buzzer_on !== buzzer_on) begin
        $display("%0t: buzzer_on mismatch, expected %0b, actual %0b",
                 $time, want.buzzer_on, buzzer_on);
        errors++;
      end
      if (want.busy !== busy) begin
        $display("%0t: busy_res mismatch, expected %0b, actual %0b",
                 $time, want.busy, busy);
        errors++;
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  op_t              in_op     = OP_TICK;
  logic [ModeW-1:0] in_mode   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_buzzer_on;
  logic             out_busy_res;

  beep_scoreboard sb;
  int             sent_items = 0;   // transactions sent, op code 3 not counted
  bit             quiet      = 1'b0;
  bit             hold_req   = 1'b0;
  bit             hold_done  = 1'b0;
  int             cycles     = 0;

  beep_pattern_sequencer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_buzzer_on (out_buzzer_on),
    .out_busy_res  (out_busy_res)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // offer one event transaction; inputs move on the falling edge only
  task automatic send(op_t op, logic [ModeW-1:0] mode);
    @(negedge clk);
    // optional idle burst before the transaction, never in the quiet tail
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_mode  <= mode;
    // hold the payload until the handshake completes
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.apply_event(op, mode);
    if (op != OP_NONE) sent_items++;
    // ask the receiver for one long stall so the block backs up
    if (sent_items == HOLD_AT) hold_req = 1'b1;
  endtask

  // receiver: random stall bursts plus the one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(out_buzzer_on, out_busy_res);
  end

  // watchdog on the whole run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("beep_pattern_sequencer test failed");
    $finish;
  end

  // main stimulus
  initial begin
    int               base;
    int               pick;
    int               r;
    int               budget;
    logic [ModeW-1:0] mode;

    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle corner cases
    send(OP_TICK, 3'd7);        // tick while idle does nothing
    send(OP_NONE, 3'd0);        // unused op code is ignored
    send(OP_STOP, 3'd0);        // stop while idle
    send(OP_START, 3'd0);       // unknown pattern numbers stay idle
    send(OP_START, 3'd6);
    send(OP_START, 3'd7);
    // shortest pattern run to completion, then one tick past idle
    send(OP_START, 3'd5);
    while (sb.running()) send(OP_TICK, 3'd0);
    send(OP_TICK, 3'd5);
    // start while running is ignored, then stop cuts the pattern
    send(OP_START, 3'd3);
    send(OP_START, 3'd1);
    send(OP_NONE, 3'd7);
    send(OP_TICK, 3'd2);
    send(OP_STOP, 3'd4);
    send(OP_TICK, 3'd0);
    send(OP_START, 3'd4);
    send(OP_TICK, 3'd1);
    send(OP_STOP, 3'd7);

    // random: mostly well-formed start-and-tick sequences, some noise
    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      quiet = (sent_items - base >= RANDOM_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: any op, any pattern number
        repeat ($urandom_range(1, 4)) begin
          send(op_t'(OpW'($urandom_range(0, 3))), ModeW'($urandom_range(0, 7)));
        end
      end else begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          mode = 3'd1;
        end else if (r < 4) begin
          mode = 3'd2;
        end else if (r == 4) begin
          r    = $urandom_range(0, 2);
          mode = (r == 0) ? 3'd0 : ((r == 1) ? 3'd6 : 3'd7);
        end else begin
          mode = ModeW'($urandom_range(3, 5));
        end
        send(OP_START, mode);
        // long patterns get a bounded tick run and are then stopped
        budget = (mode == 3'd1 || mode == 3'd2) ? $urandom_range(100, 700) : CYCLE_LIMIT;
        // keep the total close to the planned item count
        if (budget > RANDOM_ITEMS - (sent_items - base)) begin
          budget = RANDOM_ITEMS - (sent_items - base);
        end
        while (sb.running() && budget > 0) begin
          budget--;
          r = $urandom_range(0, 149);
          if (r == 0) begin
            send(OP_STOP, ModeW'($urandom_range(0, 7)));
          end else if (r == 1) begin
            send(OP_START, ModeW'($urandom_range(0, 7)));
          end else if (r == 2) begin
            send(OP_NONE, ModeW'($urandom_range(0, 7)));
          end else begin
            send(OP_TICK, ModeW'($urandom_range(0, 7)));
          end
        end
        if (sb.running()) send(OP_STOP, ModeW'($urandom_range(0, 7)));
        repeat ($urandom_range(0, 2)) send(OP_TICK, ModeW'($urandom_range(0, 7)));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then watch a few more cycles for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("beep_pattern_sequencer test passed");
    end else begin
      $display("beep_pattern_sequencer test failed");
    end
    $finish;
  end

endmodule
